// ===== rtl/core/rsap_pkg.sv =====
// Package for the ride statistics block: widths, register indexes, opcodes.
// Used by every module in rtl/core.
package rsap_pkg;
    localparam int WinDepth  = 8;
    localparam int WinIdxW   = $clog2(WinDepth);
    localparam int WinFillW  = $clog2(WinDepth + 1);
    localparam int SpdW      = 17;
    localparam int SumW      = SpdW + WinIdxW;
    localparam int DistW     = 40;
    localparam int TickW     = 32;
    localparam int LapW      = 11;
    localparam int MaxLaps   = 64;
    localparam int DivQW     = 40;
    localparam int CntW      = 6;

    localparam logic [SpdW-1:0]  SpdMax  = '1;
    localparam logic [DistW-1:0] DistMax = '1;
    localparam logic [TickW-1:0] TickMax = '1;

    localparam logic [1:0] RegPause  = 2'd0;
    localparam logic [1:0] RegResume = 2'd1;
    localparam logic [1:0] RegDelay  = 2'd2;
    localparam logic [1:0] RegMoving = 2'd3;

    localparam logic OpTick = 1'b0;
    localparam logic OpLap  = 1'b1;

    typedef enum logic [1:0] {
        t_ACTIVE  = 2'd0,
        t_WAITING = 2'd1,
        t_PAUSED  = 2'd2
    } t_pause;

    // Start, busy and done signals between the controller and the serial divider.
    typedef struct packed {
        logic start;
        logic busy;
        logic done;
    } t_div_ctl;
endpackage

// ===== rtl/core/rsap_div.sv =====
// Bit-serial restoring divider: one quotient bit per cycle, saturates to 17 bits.
// Depends on rsap_pkg.
module rsap_div
    import rsap_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [DivQW-1:0] i_num,
    input  logic [TickW-1:0] i_den,
    output t_div_ctl         o_ctl,
    output logic [SpdW-1:0]  o_quo
);
    logic [DivQW-1:0] r_num, n_num;
    logic [DivQW-1:0] r_quo, n_quo;
    logic [TickW:0]   r_rem, n_rem;
    logic [TickW-1:0] r_den;
    logic [CntW-1:0]  r_cnt, n_cnt;
    logic             r_busy, r_done, r_zero;
    logic [TickW+1:0] w_try;

    assign w_try = {r_rem, r_num[DivQW-1]} - {2'b0, r_den};

    always_comb begin
        n_rem = r_rem;
        n_num = r_num << 1;
        n_quo = r_quo << 1;
        n_cnt = r_cnt + 1'b1;
        if (!w_try[TickW+1]) begin
            n_rem    = w_try[TickW:0];
            n_quo[0] = 1'b1;
        end else begin
            n_rem = {r_rem[TickW-1:0], r_num[DivQW-1]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            // Done pulses for one cycle after the last quotient bit.
            r_done <= !i_start && r_busy && (r_cnt == CntW'(DivQW - 1));
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_rem  <= '0;
                r_num  <= i_num;
                r_den  <= i_den;
                r_quo  <= '0;
                r_zero <= (i_den == '0);
            end else if (r_busy) begin
                r_rem <= n_rem;
                r_num <= n_num;
                r_quo <= n_quo;
                r_cnt <= n_cnt;
                if (r_cnt == CntW'(DivQW - 1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_comb begin
        if (r_zero)
            o_quo = '0;
        else if (r_quo[DivQW-1:SpdW] != '0)
            o_quo = SpdMax;
        else
            o_quo = r_quo[SpdW-1:0];
    end

    assign o_ctl = '{start: i_start, busy: r_busy, done: r_done};
endmodule

// ===== rtl/core/rsap_window.sv =====
// Moving-average window: sample shift line, running sum, fill count, and a
// bit-serial divide of the sum by the fill count. Depends on rsap_pkg.
module rsap_window
    import rsap_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [SpdW-1:0]  i_speed,
    output logic             o_done,
    output logic [SpdW-1:0]  o_avg,
    output logic [SpdW-1:0]  o_last
);
    logic [SpdW-1:0]     r_win [WinDepth];
    logic [WinFillW-1:0] r_fill;
    logic [SumW-1:0]     r_sum;
    logic [SumW-1:0]     r_rem;
    logic [SumW-1:0]     r_quo;
    logic [4:0]          r_cnt;
    logic                r_busy;
    logic [SumW:0]       w_try;

    assign w_try  = {1'b0, r_rem[SumW-2:0], r_quo[SumW-1]} - (SumW+1)'(r_fill);
    assign o_last = r_win[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < WinDepth; k++) r_win[k] <= '0;
            r_fill <= '0;
            r_sum  <= '0;
            r_busy <= 1'b0;
            o_done <= 1'b0;
            o_avg  <= '0;
        end else begin
            o_done <= !i_push && r_busy && (r_cnt == 5'(SumW));
            if (i_push) begin
                // Newest sample sits at index 0; the oldest drops off the end.
                for (int k = WinDepth - 1; k > 0; k--) r_win[k] <= r_win[k-1];
                r_win[0] <= i_speed;
                if (r_fill == WinFillW'(WinDepth))
                    r_sum <= r_sum - SumW'(r_win[WinDepth-1]) + SumW'(i_speed);
                else begin
                    r_sum  <= r_sum + SumW'(i_speed);
                    r_fill <= r_fill + 1'b1;
                end
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy && r_cnt == 5'd0) begin
                r_quo <= r_sum;
                r_rem <= '0;
                r_cnt <= 5'd1;
            end else if (r_busy) begin
                if (!w_try[SumW]) begin
                    r_rem <= w_try[SumW-1:0];
                    r_quo <= {r_quo[SumW-2:0], 1'b1};
                end else begin
                    r_rem <= {r_rem[SumW-2:0], r_quo[SumW-1]};
                    r_quo <= {r_quo[SumW-2:0], 1'b0};
                end
                if (r_cnt == 5'(SumW)) begin
                    r_busy <= 1'b0;
                end
                r_cnt <= r_cnt + 1'b1;
            end else if (o_done) begin
                o_avg <= r_quo[SpdW-1:0];
            end
        end
    end
endmodule

// ===== rtl/core/ride_statistics_auto_pause.sv =====
// Ride statistics with auto pause. One request is taken at a time. A tick's
// result passes through the window average, the counter update, the serial
// trip average divide and the output step; a lap mark's result goes straight
// to the same divider and then to the output step. The input is ready again in
// the same cycle as the result is presented, and the output step holds while
// an earlier result is still waiting to be taken.
// Configuration writes are taken at any time but must only be made while idle.
// Depends on rsap_pkg, rsap_window and rsap_div.
module ride_statistics_auto_pause
    import rsap_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic [1:0]   i_cfg_index,
    input  logic [16:0]  i_cfg_data,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [23:0]  s_axis_tdata,  // speed_mm_s[16:0], zero pad
    input  logic         s_axis_tuser,  // op
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // current[16:0] max[33:17] filtered[50:34] paused[51] total_dist[91:52]
    // trip_dist[131:92] ride[163:132] total_t[195:164] avg[212:196]
    // lap_no[223:213] lap_dist[263:224] lap_t[295:264]
    output logic [295:0] m_axis_tdata
);
    typedef enum logic [2:0] {S_IDLE, S_WIN, S_UPD, S_DIV, S_OUT} t_st;

    t_st r_st;
    logic [SpdW-1:0] r_pth, r_rth, r_mth, r_v, r_peak;
    logic [11:0] r_dly;
    t_pause r_ps;
    logic [15:0] r_idle;
    logic [DistW-1:0] r_tot, r_trip, r_lsd, r_ldist;
    logic [TickW-1:0] r_ride, r_tt, r_lst, r_lt;
    logic [LapW-1:0] r_laps, r_lapno;
    logic r_op, r_lapok, r_dstart;
    logic [SpdW-1:0] r_avgout;
    logic [DistW-1:0] r_dnum;
    logic [TickW-1:0] r_dden;
    logic [295:0] r_out;

    logic w_wdone;
    logic [SpdW-1:0] w_avg, w_last, w_quo;
    t_div_ctl w_dctl;

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = (r_st == S_IDLE);
    assign m_axis_tdata  = r_out;

    rsap_window u_win (
        .i_clk, .i_rst_n,
        .i_push  (s_axis_tvalid && s_axis_tready && s_axis_tuser == OpTick),
        .i_speed (s_axis_tdata[SpdW-1:0]),
        .o_done  (w_wdone),
        .o_avg   (w_avg),
        .o_last  (w_last)
    );

    rsap_div u_div (
        .i_clk, .i_rst_n,
        .i_start (r_dstart),
        .i_num   (r_dnum),
        .i_den   (r_dden),
        .o_ctl   (w_dctl),
        .o_quo   (w_quo)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE;
            r_pth <= 17'd833; r_rth <= 17'd1389; r_dly <= 12'd5; r_mth <= 17'd278;
            r_ps <= t_ACTIVE; r_idle <= '0; r_peak <= '0;
            r_tot <= '0; r_trip <= '0; r_ride <= '0; r_tt <= '0;
            r_laps <= '0; r_lsd <= '0; r_lst <= '0;
            r_dstart <= 1'b0;
            m_axis_tvalid <= 1'b0;
        end else begin
            // The divider starts right after a lap mark is taken or a tick is counted.
            r_dstart <= (r_st == S_IDLE && s_axis_tvalid && s_axis_tuser == OpLap) ||
                        (r_st == S_UPD);
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    RegPause:  r_pth <= i_cfg_data;
                    RegResume: r_rth <= i_cfg_data;
                    RegDelay:  r_dly <= i_cfg_data[11:0];
                    RegMoving: r_mth <= i_cfg_data;
                    default: ;
                endcase
            end
            if (m_axis_tvalid && m_axis_tready) m_axis_tvalid <= 1'b0;
            unique case (r_st)
                S_IDLE: if (s_axis_tvalid) begin
                    r_op <= s_axis_tuser;
                    r_v  <= s_axis_tdata[SpdW-1:0];
                    if (s_axis_tuser == OpTick) begin
                        if (s_axis_tdata[SpdW-1:0] > r_peak) r_peak <= s_axis_tdata[SpdW-1:0];
                        r_st <= S_WIN;
                    end else begin
                        r_lapok <= (r_laps < LapW'(MaxLaps));
                        r_ldist <= r_trip - r_lsd;
                        r_lt    <= r_ride - r_lst;
                        r_dnum  <= r_trip - r_lsd;
                        r_dden  <= r_ride - r_lst;
                        r_st <= S_DIV;
                    end
                end
                S_WIN: if (w_wdone) r_st <= S_UPD;
                S_UPD: begin
                    // w_avg is valid now; step the pause machine and counters.
                    logic below, above, mov;
                    t_pause ps;
                    logic [DistW:0] st, sp;
                    logic [TickW-1:0] rn;
                    logic [DistW-1:0] nt;
                    below = w_avg < r_pth;
                    above = w_avg > r_rth;
                    mov   = w_avg >= r_mth;
                    ps = r_ps;
                    unique case (r_ps)
                        t_ACTIVE: if (below) begin ps = t_WAITING; r_idle <= '0; end
                        t_WAITING: if (above) ps = t_ACTIVE;
                            else begin
                                logic [15:0] ni;
                                ni = (r_idle != 16'hFFFF) ? r_idle + 1'b1 : r_idle;
                                r_idle <= ni;
                                if (17'(ni) >= {4'd0, r_dly, 1'b0}) ps = t_PAUSED;
                            end
                        default: if (above) ps = t_ACTIVE;
                    endcase
                    r_ps <= ps;
                    st = {1'b0, r_tot} + (DistW+1)'(r_v);
                    sp = {1'b0, r_trip} + (DistW+1)'(r_v);
                    rn = r_ride;
                    nt = r_trip;
                    if (mov) begin
                        r_tot <= st[DistW] ? DistMax : st[DistW-1:0];
                        if (ps != t_PAUSED) begin
                            nt = sp[DistW] ? DistMax : sp[DistW-1:0];
                            if (r_ride != TickMax) rn = r_ride + 1'b1;
                        end
                    end
                    r_trip <= nt;
                    r_dnum <= nt;
                    r_ride <= rn;
                    r_dden <= rn;
                    if (r_tt != TickMax) r_tt <= r_tt + 1'b1;
                    r_st <= S_DIV;
                end
                S_DIV: if (w_dctl.done) begin
                    if (r_op == OpLap && r_lapok) begin
                        r_avgout <= w_quo;
                        r_laps  <= r_laps + 1'b1;
                        r_lapno <= r_laps + 1'b1;
                        r_lsd   <= r_trip;
                        r_lst   <= r_ride;
                    end else if (r_op == OpLap) begin
                        r_avgout <= '0; r_lapno <= '0; r_ldist <= '0; r_lt <= '0;
                    end else begin
                        r_avgout <= w_quo; r_lapno <= '0; r_ldist <= '0; r_lt <= '0;
                    end
                    r_st <= S_OUT;
                end
                S_OUT: if (!m_axis_tvalid) begin
                    r_out <= {r_lt, r_ldist, r_lapno, r_avgout, r_tt, r_ride, r_trip,
                              r_tot, (r_ps == t_PAUSED), w_avg, r_peak, w_last};
                    m_axis_tvalid <= 1'b1;
                    r_st <= S_IDLE;
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end
endmodule
